// ----- rtl/adjacency_matrix_graph_store_top_defines.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_TOP_DEFINES_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked on every rising clk_i edge outside reset.
`define AMG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Condition that must never hold outside reset.
`define AMG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define AMG_ASSERT(lbl, prop)
`define AMG_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- rtl/amg_pkg.sv -----
package amg_pkg;

  localparam int unsigned NUM_V    = 16;
  localparam int unsigned VIDX_W   = $clog2(NUM_V);
  localparam int unsigned CELL_W   = 2 * VIDX_W;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned ACT_W    = 5;

  typedef enum logic [2:0] {
    REQ_INSERT   = 3'd0,
    REQ_REMOVE   = 3'd1,
    REQ_LOOKUP   = 3'd2,
    REQ_NEXT_OUT = 3'd3,
    REQ_NEXT_IN  = 3'd4
  } amg_req_e;

  typedef enum logic {
    CFG_DIRECTED = 1'b0,
    CFG_ACTIVE   = 1'b1
  } amg_cfg_e;

  // One mark write, optionally mirrored onto the transposed cell.
  typedef struct packed {
    logic              en;
    logic              val;
    logic              mirror;
    logic [VIDX_W-1:0] row;
    logic [VIDX_W-1:0] col;
  } amg_mark_upd_t;

  typedef struct packed {
    logic              hit;
    logic [VIDX_W-1:0] idx;
  } amg_scan_t;

endpackage

// ----- rtl/amg_mark_array.sv -----
module amg_mark_array
  import amg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  amg_mark_upd_t     upd_i,
  input  logic [VIDX_W-1:0] row_sel_i,
  input  logic [VIDX_W-1:0] col_sel_i,
  output logic [NUM_V-1:0]  row_o,
  output logic [NUM_V-1:0]  col_o,
  output logic              cell_o
);

  logic [NUM_V-1:0] marks_q [NUM_V];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '{default: '0};
    end else if (upd_i.en) begin
      marks_q[upd_i.row][upd_i.col] <= upd_i.val;
      if (upd_i.mirror) begin
        marks_q[upd_i.col][upd_i.row] <= upd_i.val;
      end
    end
  end

  assign row_o  = marks_q[row_sel_i];
  assign cell_o = marks_q[row_sel_i][col_sel_i];

  always_comb begin
    for (int k = 0; k < NUM_V; k++) begin
      col_o[k] = marks_q[k][col_sel_i];
    end
  end

endmodule

// ----- rtl/amg_scan.sv -----
module amg_scan
  import amg_pkg::*;
(
  input  logic [NUM_V-1:0]  vec_i,
  input  logic [VIDX_W-1:0] from_i,
  input  logic [ACT_W-1:0]  limit_i,
  output amg_scan_t         scan_o
);

  logic [NUM_V-1:0] live;

  always_comb begin
    for (int k = 0; k < NUM_V; k++) begin
      live[k] = vec_i[k] && (VIDX_W'(k) >= from_i) && (ACT_W'(k) < limit_i);
    end
  end

  // Lowest live index wins: walk down so the last hit seen is the lowest.
  always_comb begin
    scan_o = '0;
    for (int k = NUM_V - 1; k >= 0; k--) begin
      if (live[k]) begin
        scan_o.hit = 1'b1;
        scan_o.idx = VIDX_W'(k);
      end
    end
  end

endmodule

// ----- rtl/amg_weight_ram.sv -----
module amg_weight_ram
  import amg_pkg::*;
(
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [CELL_W-1:0]   waddr_i,
  input  logic [WEIGHT_W-1:0] wdata_i,
  input  logic                re_i,
  input  logic [CELL_W-1:0]   raddr_i,
  output logic [WEIGHT_W-1:0] rdata_o
);

  logic [WEIGHT_W-1:0] mem_q [NUM_V * NUM_V];
  logic [WEIGHT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/adjacency_matrix_graph_store_top.sv -----
// Accepted beats are decoded in S_IDLE; S_FINAL loads the result into the
// output register, and one item is decoded while the previous result may
// still wait there. The accept cycle marks and reads or writes the weight
// RAM; S_FINAL writes the mirrored weight through the single RAM write port.
// No new item is taken until S_FINAL has loaded the output register.
// Reset: asynchronous, clears every present mark and the edge count, and
// restores the config defaults (undirected, 16 vertices).
`include "adjacency_matrix_graph_store_top_defines.svh"

module adjacency_matrix_graph_store_top
  import amg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [ACT_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          req_type_i,
  input  logic [VIDX_W-1:0]   vertex_a_i,
  input  logic [VIDX_W-1:0]   vertex_b_i,
  input  logic [WEIGHT_W-1:0] edge_weight_i,
  input  logic [VIDX_W-1:0]   scan_from_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o,
  output logic [VIDX_W-1:0]   found_vertex_o,
  output logic [WEIGHT_W-1:0] weight_out_o,
  output logic [COUNT_W-1:0]  edge_total_o
);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FINAL = 2'b10
  } amg_state_e;

  amg_state_e state_q, state_d;

  logic               directed_q;
  logic [ACT_W-1:0]   active_q;
  logic [COUNT_W-1:0] count_q, count_d;

  logic              hit_q, hit_d;
  logic [VIDX_W-1:0] fv_q, fv_d;
  logic              mirror_q, mirror_d;
  logic [CELL_W-1:0] maddr_q;
  logic [WEIGHT_W-1:0] mweight_q;

  logic                out_valid_q;
  logic                out_found_q;
  logic [VIDX_W-1:0]   out_fv_q;
  logic [WEIGHT_W-1:0] out_weight_q;
  logic [COUNT_W-1:0]  out_total_q;

  logic              in_fire, slot_free, finish;
  logic [ACT_W-1:0]  n_act;
  logic              a_ok, b_ok;
  amg_req_e          req;
  amg_mark_upd_t     upd;
  logic [NUM_V-1:0]  row_marks, col_marks;
  logic              cell_mark;
  amg_scan_t         scan;
  logic              prim_we, re;
  logic [CELL_W-1:0] raddr, waddr;
  logic [WEIGHT_W-1:0] wdata, rdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign finish     = (state_q == S_FINAL) && slot_free;

  assign n_act = (active_q > ACT_W'(NUM_V)) ? ACT_W'(NUM_V) : active_q;
  assign a_ok  = ACT_W'(vertex_a_i) < n_act;
  assign b_ok  = ACT_W'(vertex_b_i) < n_act;
  assign req   = amg_req_e'(req_type_i);

  amg_mark_array u_marks (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (upd),
    .row_sel_i (vertex_a_i),
    .col_sel_i (vertex_b_i),
    .row_o     (row_marks),
    .col_o     (col_marks),
    .cell_o    (cell_mark)
  );

  amg_scan u_scan (
    .vec_i   ((req == REQ_NEXT_IN) ? col_marks : row_marks),
    .from_i  (scan_from_i),
    .limit_i (n_act),
    .scan_o  (scan)
  );

  // Decode the accepted beat: mark update, primary RAM access, count step.
  always_comb begin
    upd      = '0;
    upd.row  = vertex_a_i;
    upd.col  = vertex_b_i;
    prim_we  = 1'b0;
    re       = 1'b0;
    raddr    = {vertex_a_i, vertex_b_i};
    count_d  = count_q;
    hit_d    = 1'b0;
    fv_d     = '0;
    mirror_d = 1'b0;
    if (in_fire) begin
      case (req)
        REQ_INSERT: begin
          if (a_ok && b_ok) begin
            upd.en     = 1'b1;
            upd.val    = 1'b1;
            upd.mirror = !directed_q;
            prim_we    = 1'b1;
            mirror_d   = !directed_q;
            if (!cell_mark && count_q != COUNT_MAX) begin
              count_d = count_q + COUNT_W'(1);
            end
          end
        end
        REQ_REMOVE: begin
          if (a_ok && b_ok) begin
            upd.en     = 1'b1;
            upd.mirror = !directed_q;
            if (cell_mark && count_q != '0) begin
              count_d = count_q - COUNT_W'(1);
            end
          end
        end
        REQ_LOOKUP: begin
          if (a_ok && b_ok) begin
            re    = 1'b1;
            hit_d = cell_mark;
          end
        end
        REQ_NEXT_OUT: begin
          if (a_ok) begin
            re    = 1'b1;
            raddr = {vertex_a_i, scan.idx};
            hit_d = scan.hit;
            fv_d  = scan.hit ? scan.idx : '0;
          end
        end
        REQ_NEXT_IN: begin
          if (b_ok) begin
            re    = 1'b1;
            raddr = {scan.idx, vertex_b_i};
            hit_d = scan.hit;
            fv_d  = scan.hit ? scan.idx : '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Primary weight in the accept cycle, mirrored weight in the next one.
  assign waddr = prim_we ? {vertex_a_i, vertex_b_i} : maddr_q;
  assign wdata = prim_we ? edge_weight_i : mweight_q;

  amg_weight_ram u_wram (
    .clk_i   (clk_i),
    .we_i    (prim_we || ((state_q == S_FINAL) && mirror_q)),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_FINAL;
      S_FINAL: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      directed_q  <= 1'b0;
      active_q    <= ACT_W'(NUM_V);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        unique case (amg_cfg_e'(cfg_index_i))
          CFG_DIRECTED: directed_q <= cfg_wdata_i[0];
          CFG_ACTIVE:   active_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the beat's decode results until the result is loaded.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hit_q     <= hit_d;
      fv_q      <= fv_d;
      mirror_q  <= mirror_d;
      maddr_q   <= {vertex_b_i, vertex_a_i};
      mweight_q <= edge_weight_i;
    end
    if (finish) begin
      out_found_q  <= hit_q;
      out_fv_q     <= fv_q;
      out_weight_q <= hit_q ? rdata : '0;
      out_total_q  <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign found_vertex_o = out_fv_q;
  assign weight_out_o   = out_weight_q;
  assign edge_total_o   = out_total_q;

  `AMG_ASSERT(a_state_onehot, $onehot(state_q))
  `AMG_ASSERT(a_fire_to_final, in_fire |=> (state_q == S_FINAL))
  `AMG_ASSERT(a_count_only_on_fire, !in_fire |=> $stable(count_q))
  `AMG_ASSERT(a_stall_holds_final, ((state_q == S_FINAL) && !slot_free) |=> (state_q == S_FINAL))
  `AMG_ASSERT_NEVER(a_no_found_on_miss, out_valid_q && !out_found_q && (out_weight_q != '0))

endmodule

// ----- tb/tb_adjacency_matrix_graph_store_top.sv -----
`timescale 1ns / 1ps

module tb_adjacency_matrix_graph_store_top;
  import amg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned COUNT_TOP   = (1 << COUNT_W) - 1;
  localparam int unsigned PHASE_ITEMS = 52;
  localparam logic [2:0]  REQ_BAD_LO  = 3'd5;
  localparam logic [2:0]  REQ_BAD_HI  = 3'd7;

  typedef struct packed {
    logic [2:0]          req;
    logic [VIDX_W-1:0]   vtx_a;
    logic [VIDX_W-1:0]   vtx_b;
    logic [WEIGHT_W-1:0] weight;
    logic [VIDX_W-1:0]   scan_start;
  } graph_req_t;

  typedef struct packed {
    logic                found;
    logic [VIDX_W-1:0]   vtx;
    logic [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]  total;
  } graph_ans_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_index_i   = 1'b0;
  logic [ACT_W-1:0]    cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [2:0]          req_type_i    = '0;
  logic [VIDX_W-1:0]   vertex_a_i    = '0;
  logic [VIDX_W-1:0]   vertex_b_i    = '0;
  logic [WEIGHT_W-1:0] edge_weight_i = '0;
  logic [VIDX_W-1:0]   scan_from_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic                found_o;
  logic [VIDX_W-1:0]   found_vertex_o;
  logic [WEIGHT_W-1:0] weight_out_o;
  logic [COUNT_W-1:0]  edge_total_o;

  adjacency_matrix_graph_store_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .edge_weight_i  (edge_weight_i),
    .scan_from_i    (scan_from_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .found_vertex_o (found_vertex_o),
    .weight_out_o   (weight_out_o),
    .edge_total_o   (edge_total_o)
  );

  // Graph mirror kept by the testbench
  bit                  edge_present [NUM_V][NUM_V];
  logic [WEIGHT_W-1:0] edge_wt      [NUM_V][NUM_V];
  bit [COUNT_W-1:0]    edge_count   = '0;
  bit                  cfg_directed = 1'b0;
  bit [ACT_W-1:0]      cfg_active   = ACT_W'(NUM_V);

  graph_req_t request_q[$];
  graph_ans_t answer_q[$];
  graph_req_t drv_item;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned err_count     = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned hold_left     = 0;
  int unsigned ready_mode    = 0;
  int unsigned mode_left     = 0;
  int unsigned ready_tick    = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic graph_ans_t apply_request(graph_req_t r);
    graph_ans_t  ans;
    int unsigned n;
    int unsigned k;
    bit          a_ok;
    bit          b_ok;
    ans  = '0;
    n    = (cfg_active > NUM_V) ? NUM_V : cfg_active;
    a_ok = r.vtx_a < n;
    b_ok = r.vtx_b < n;
    case (r.req)
      REQ_INSERT: begin
        if (a_ok && b_ok) begin
          if (!edge_present[r.vtx_a][r.vtx_b] && edge_count != COUNT_TOP)
            edge_count++;
          edge_present[r.vtx_a][r.vtx_b] = 1'b1;
          edge_wt[r.vtx_a][r.vtx_b]      = r.weight;
          if (!cfg_directed) begin
            edge_present[r.vtx_b][r.vtx_a] = 1'b1;
            edge_wt[r.vtx_b][r.vtx_a]      = r.weight;
          end
        end
      end
      REQ_REMOVE: begin
        if (a_ok && b_ok) begin
          if (edge_present[r.vtx_a][r.vtx_b] && edge_count != 0)
            edge_count--;
          edge_present[r.vtx_a][r.vtx_b] = 1'b0;
          if (!cfg_directed)
            edge_present[r.vtx_b][r.vtx_a] = 1'b0;
        end
      end
      REQ_LOOKUP: begin
        if (a_ok && b_ok && edge_present[r.vtx_a][r.vtx_b]) begin
          ans.found  = 1'b1;
          ans.weight = edge_wt[r.vtx_a][r.vtx_b];
        end
      end
      REQ_NEXT_OUT: begin
        if (a_ok)
          for (k = r.scan_start; k < n && !ans.found; k++)
            if (edge_present[r.vtx_a][k]) begin
              ans.found  = 1'b1;
              ans.vtx    = VIDX_W'(k);
              ans.weight = edge_wt[r.vtx_a][k];
            end
      end
      REQ_NEXT_IN: begin
        if (b_ok)
          for (k = r.scan_start; k < n && !ans.found; k++)
            if (edge_present[k][r.vtx_b]) begin
              ans.found  = 1'b1;
              ans.vtx    = VIDX_W'(k);
              ans.weight = edge_wt[k][r.vtx_b];
            end
      end
      default: ;
    endcase
    ans.total = edge_count;
    return ans;
  endfunction

  function automatic void queue_req(logic [2:0] r, logic [VIDX_W-1:0] a,
                                    logic [VIDX_W-1:0] b, logic [WEIGHT_W-1:0] w,
                                    logic [VIDX_W-1:0] s);
    graph_req_t t;
    t.req        = r;
    t.vtx_a      = a;
    t.vtx_b      = b;
    t.weight     = w;
    t.scan_start = s;
    request_q.push_back(t);
  endfunction

  function automatic logic [VIDX_W-1:0] pick_index(int unsigned n);
    if ($urandom_range(0, 9) == 0)
      return VIDX_W'($urandom_range(0, NUM_V - 1));
    return VIDX_W'($urandom_range(0, n - 1));
  endfunction

  task automatic write_reg(amg_cfg_e idx, logic [ACT_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_DIRECTED)
      cfg_directed = val[0];
    else
      cfg_active = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(bit directed, logic [ACT_W-1:0] active);
    write_reg(CFG_DIRECTED, ACT_W'(directed));
    write_reg(CFG_ACTIVE, active);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || answer_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_random(bit directed, logic [ACT_W-1:0] active, bit long_hold);
    int unsigned n;
    int unsigned i;
    int unsigned roll;
    logic [2:0]          r;
    logic [WEIGHT_W-1:0] w;
    set_config(directed, active);
    n = (active > NUM_V) ? NUM_V : active;
    if (long_hold)
      hold_requests++;
    for (i = 0; i < PHASE_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30)      r = REQ_INSERT;
      else if (roll < 45) r = REQ_REMOVE;
      else if (roll < 62) r = REQ_LOOKUP;
      else if (roll < 78) r = REQ_NEXT_OUT;
      else if (roll < 95) r = REQ_NEXT_IN;
      else                r = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
      case ($urandom_range(0, 7))
        0:       w = '0;
        1:       w = '1;
        default: w = WEIGHT_W'($urandom);
      endcase
      queue_req(r, pick_index(n), pick_index(n), w, pick_index(n));
    end
    drain();
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      req_type_i    <= '0;
      vertex_a_i    <= '0;
      vertex_b_i    <= '0;
      edge_weight_i <= '0;
      scan_from_i   <= '0;
      burst_left    = 1;
      gap_left      = 0;
    end else begin
      if (in_valid_i && in_ready_o)
        answer_q.push_back(apply_request(drv_item));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          drv_item = request_q.pop_front();
          in_valid_i    <= 1'b1;
          req_type_i    <= drv_item.req;
          vertex_a_i    <= drv_item.vtx_a;
          vertex_b_i    <= drv_item.vtx_b;
          edge_weight_i <= drv_item.weight;
          scan_from_i   <= drv_item.scan_start;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left   = $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      ready_tick++;
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 80);
        end else begin
          mode_left--;
        end
        case (ready_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= (ready_tick % 4 == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    graph_ans_t exp_ans;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        $error("result beat with no request outstanding");
        err_count++;
      end else begin
        exp_ans = answer_q.pop_front();
        if (found_o !== exp_ans.found) begin
          $error("found: expected %0d, actual %0d", exp_ans.found, found_o);
          err_count++;
        end
        if (found_vertex_o !== exp_ans.vtx) begin
          $error("found_vertex: expected %0d, actual %0d", exp_ans.vtx, found_vertex_o);
          err_count++;
        end
        if (weight_out_o !== exp_ans.weight) begin
          $error("weight_out: expected %0h, actual %0h", exp_ans.weight, weight_out_o);
          err_count++;
        end
        if (edge_total_o !== exp_ans.total) begin
          $error("edge_total: expected %0d, actual %0d", exp_ans.total, edge_total_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Undirected, full size: empty lookup, mirroring, re-insert, scan ends
    queue_req(REQ_LOOKUP,   0,  0, 16'h0000,  0);
    queue_req(REQ_INSERT,   0, 15, 16'hFFFF,  0);
    queue_req(REQ_LOOKUP,  15,  0, 16'h0000,  0);
    queue_req(REQ_INSERT,   0, 15, 16'h0000, 15);
    queue_req(REQ_NEXT_OUT, 0,  3, 16'h0000,  0);
    queue_req(REQ_NEXT_IN,  3,  0, 16'h0000,  0);
    queue_req(REQ_NEXT_OUT, 0,  0, 16'h0000, 15);
    queue_req(REQ_INSERT,  15, 15, 16'hA5A5,  0);
    queue_req(REQ_NEXT_IN,  0, 15, 16'h0000,  0);
    queue_req(REQ_REMOVE,  15,  0, 16'h0000,  0);
    queue_req(REQ_REMOVE,  15,  0, 16'hFFFF, 15);
    queue_req(REQ_INSERT,   7,  8, 16'h1234,  0);
    queue_req(REQ_BAD_LO,  15, 15, 16'hFFFF, 15);
    queue_req(REQ_BAD_HI,   0,  0, 16'h0000,  0);
    drain();

    // Shrunk vertex range hides entries; scan start past the range misses
    write_reg(CFG_ACTIVE, 5'd8);
    queue_req(REQ_INSERT,   8,  2, 16'h0001,  0);
    queue_req(REQ_LOOKUP,   7,  8, 16'h0000,  0);
    queue_req(REQ_NEXT_IN,  0,  7, 16'h0000,  9);
    drain();

    // Zero active vertices: everything inactive
    write_reg(CFG_ACTIVE, 5'd0);
    queue_req(REQ_LOOKUP,   0,  0, 16'h0000,  0);
    queue_req(REQ_INSERT,   0,  0, 16'h0001,  0);
    drain();

    // Above the vertex limit: clamp to full size
    write_reg(CFG_ACTIVE, 5'd31);
    queue_req(REQ_NEXT_OUT, 15, 0, 16'h0000,  0);
    queue_req(REQ_LOOKUP,    8, 7, 16'h0000,  0);
    drain();

    write_reg(CFG_ACTIVE, 5'd1);
    queue_req(REQ_INSERT,   0,  0, 16'h0007,  0);
    queue_req(REQ_NEXT_OUT, 0,  0, 16'h0000,  0);
    drain();

    // Directed: no mirror, then remove marks one at a time so the count
    // bottoms out while a mark is still left
    set_config(1'b1, ACT_W'(NUM_V));
    queue_req(REQ_INSERT,   3,  4, 16'hBEEF,  0);
    queue_req(REQ_LOOKUP,   4,  3, 16'h0000,  0);
    queue_req(REQ_REMOVE,  15, 15, 16'h0000,  0);
    queue_req(REQ_REMOVE,   7,  8, 16'h0000,  0);
    queue_req(REQ_REMOVE,   8,  7, 16'h0000,  0);
    queue_req(REQ_REMOVE,   0,  0, 16'h0000,  0);
    queue_req(REQ_REMOVE,   3,  4, 16'h0000,  0);
    drain();

    run_random(1'b0, ACT_W'(NUM_V), 1'b0);
    run_random(1'b1, ACT_W'(NUM_V), 1'b1);
    run_random(1'b0, 5'd4, 1'b0);
    run_random(1'b1, 5'd2, 1'b0);
    run_random(1'b0, 5'd1, 1'b0);
    run_random(1'b1, ACT_W'($urandom_range(3, NUM_V - 1)), 1'b0);
    run_random(1'b0, ACT_W'($urandom_range(NUM_V + 1, (1 << ACT_W) - 1)), 1'b0);
    run_random(1'($urandom_range(0, 1)), ACT_W'(NUM_V), 1'b0);

    repeat (20) @(posedge clk_i);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
